// ===== rtl/eeml_pkg.sv =====
// Shared types and constants for the equirectangular environment map lookup.
// Holds the CORDIC arc table, configuration register indexes and the pipeline
// sideband type. No dependencies.
package eeml_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_GAIN = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam int ARC_LEN = 26;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [31:0] ARC_TAB [ARC_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20
  };

  typedef struct packed {
    logic               valid;
    logic               cmd;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        load_address;
    logic [15:0]        load_red;
    logic [15:0]        load_green;
    logic [15:0]        load_blue;
    logic               elev_zero;
    logic               azim_zero;
  } side_t;

endpackage

// ===== rtl/eeml_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; advanced by the shared pipeline enable.
module eeml_isqrt #(
  parameter int NW = 48
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       n_in,
  output logic [NW/2-1:0]     root_out
);

  localparam int K = NW / 2;
  localparam int RW = K + 2;

  logic [NW-1:0] n_r    [K];
  logic [RW-1:0] rem_r  [K];
  logic [K-1:0]  root_r [K];

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic [NW-1:0] n_i;
    logic [RW-1:0] rem_i;
    logic [K-1:0]  root_i;
    logic [RW-1:0] rem_t;
    logic [RW-1:0] test;
    logic [RW-1:0] rem_nxt;
    logic [K-1:0]  root_nxt;

    if (j == 0) begin : g_first
      assign n_i = n_in;
      assign rem_i = '0;
      assign root_i = '0;
    end else begin : g_next
      assign n_i = n_r[j-1];
      assign rem_i = rem_r[j-1];
      assign root_i = root_r[j-1];
    end

    always_comb begin
      rem_t = {rem_i[RW-3:0], n_i[NW-1-2*j -: 2]};
      test = {root_i, 2'b01};
      if (rem_t >= test) begin
        rem_nxt = rem_t - test;
        root_nxt = {root_i[K-2:0], 1'b1};
      end else begin
        rem_nxt = rem_t;
        root_nxt = {root_i[K-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j] <= n_i;
        rem_r[j] <= rem_nxt;
        root_r[j] <= root_nxt;
      end
    end
  end

  assign root_out = root_r[K-1];

endmodule

// ===== rtl/eeml_cordic.sv =====
// Pipelined CORDIC vectoring, one rotation per stage, angle in turns * 2^32.
// Depends on eeml_pkg for the arc table; advanced by the shared enable.
module eeml_cordic #(
  parameter int DW = 27,
  parameter int STEPS = 18
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  input  logic [31:0]          acc_in,
  output logic [31:0]          acc_out
);
  import eeml_pkg::*;

  logic signed [DW-1:0] x_r   [STEPS];
  logic signed [DW-1:0] y_r   [STEPS];
  logic [31:0]          acc_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [DW-1:0] x_i;
    logic signed [DW-1:0] y_i;
    logic [31:0]          a_i;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    if (i == 0) begin : g_first
      assign x_i = x_in;
      assign y_i = y_in;
      assign a_i = acc_in;
    end else begin : g_next
      assign x_i = x_r[i-1];
      assign y_i = y_r[i-1];
      assign a_i = acc_r[i-1];
    end

    assign dx = y_i >>> i;
    assign dy = x_i >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_i[DW-1]) begin
          x_r[i] <= x_i + dx;
          y_r[i] <= y_i - dy;
          acc_r[i] <= a_i + ARC_TAB[i];
        end else begin
          x_r[i] <= x_i - dx;
          y_r[i] <= y_i + dy;
          acc_r[i] <= a_i - ARC_TAB[i];
        end
      end
    end
  end

  assign acc_out = acc_r[STEPS-1];

endmodule

// ===== rtl/equirect_env_map_lookup.sv =====
// Top level: equirectangular environment map lookup with texel store.
// Depends on eeml_pkg, eeml_isqrt and eeml_cordic.
//
//   channel  ports                         direction
//   in       in_valid/in_ready + fields    load texel or look up direction
//   out      out_valid/out_ready + rgb     one beat per lookup
//   cfg      cfg_valid/cfg_ready/idx/data  register write, always ready
//
// One beat enters per cycle unless a stalled result holds it; the path runs through the
// 24-stage square root, the CORDIC chain, the index stages and the three-stage
// store depth reduction. No clearing pass: store entries are valid once loaded.
// A stalled result holds the whole pipeline; bubbles stay in place.
// Reset clears valid bits and loads the register defaults.
module equirect_env_map_lookup #(
  parameter int MAX_DIM = 256,
  parameter int STORE_DEPTH = 65536,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic signed [15:0]           in_dir_x,
  input  logic signed [15:0]           in_dir_y,
  input  logic signed [15:0]           in_dir_z,
  input  logic [15:0]                  in_load_address,
  input  logic [15:0]                  in_load_red,
  input  logic [15:0]                  in_load_green,
  input  logic [15:0]                  in_load_blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [23:0]                  out_red,
  output logic [23:0]                  out_green,
  output logic [23:0]                  out_blue,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [eeml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eeml_pkg::CFG_DATA_W-1:0] cfg_data
);
  import eeml_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int STEPS = AB + 2;
  localparam int DROP = 32 - AB;
  localparam int FULL = 1 << AB;
  localparam int HALF = FULL / 2;
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int IW = $clog2(MAX_DIM * MAX_DIM);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int NW = 48;
  localparam int K = NW / 2;
  localparam int EDW = 36;
  localparam int ADW = 27;
  localparam int PE = 3 + K;
  localparam int PF = PE + STEPS + 1;
  localparam int PG = PF + 1;
  localparam int PH = PG + 1;
  localparam int PI = PH + 4;
  localparam logic [IW-1:0] RECIP = IW'((64'd1 << IW) / 64'(STORE_DEPTH));
  localparam logic [IW-1:0] DEPTH_K = IW'(STORE_DEPTH);

  logic adv;
  logic [8:0]  width_r;
  logic [8:0]  height_r;
  logic [15:0] gain_r;
  logic [DIMW-1:0] w_c;
  logic [DIMW-1:0] h_c;

  side_t sb_r   [PI+1];
  side_t sb_nxt [PI+1];

  logic [31:0] xx_r;
  logic [31:0] yy_r;
  logic [31:0] nsum_r;
  logic [K-1:0] root;

  logic signed [EDW-1:0] ex_r;
  logic signed [EDW-1:0] ey_r;
  logic signed [ADW-1:0] ax_r;
  logic signed [ADW-1:0] ay_r;
  logic [31:0] aacc_r;
  logic [31:0] acc_e;
  logic [31:0] acc_a;

  logic [AB:0] u_r;
  logic [AB:0] v_r;
  logic [DIMW-1:0] col_r;
  logic [DIMW-1:0] row_r;
  logic [IW-1:0] idx_r;
  logic [2*IW-1:0] qp;
  logic [IW-1:0] q_r;
  logic [IW-1:0] idx_q_r;
  logic [IW-1:0] qd;
  logic [IW-1:0] rm_r;
  logic [IW-1:0] md_r;
  logic [47:0] rd_r;
  logic [47:0] mem [STORE_DEPTH];

  logic out_valid_r;
  logic [23:0] out_red_r;
  logic [23:0] out_green_r;
  logic [23:0] out_blue_r;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256;
      height_r <= 9'd256;
      gain_r <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: width_r <= cfg_data[8:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[8:0];
        CFG_POWER_GAIN: gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_c = (width_r == 9'd0) ? DIMW'(1) :
               ((32'(width_r) > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(width_r));
  assign h_c = (height_r == 9'd0) ? DIMW'(1) :
               ((32'(height_r) > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(height_r));

  // sideband shift line
  always_comb begin
    for (int k = 0; k <= PI; k++) begin
      if (k == 0) begin
        sb_nxt[k].valid = in_valid;
        sb_nxt[k].cmd = in_cmd;
        sb_nxt[k].dir_x = in_dir_x;
        sb_nxt[k].dir_y = in_dir_y;
        sb_nxt[k].dir_z = in_dir_z;
        sb_nxt[k].load_address = in_load_address;
        sb_nxt[k].load_red = in_load_red;
        sb_nxt[k].load_green = in_load_green;
        sb_nxt[k].load_blue = in_load_blue;
        sb_nxt[k].elev_zero = 1'b0;
        sb_nxt[k].azim_zero = 1'b0;
      end else begin
        sb_nxt[k] = sb_r[k-1];
      end
    end
    sb_nxt[PE].elev_zero = (sb_r[PE-1].dir_z == 16'sd0) && (root == '0);
    sb_nxt[PE].azim_zero = (sb_r[PE-1].dir_x == 16'sd0) && (sb_r[PE-1].dir_y == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= PI; k++) begin
        sb_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k <= PI; k++) begin
        sb_r[k] <= sb_nxt[k];
      end
    end
  end

  // squares and horizontal length
  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r <= 32'($signed(sb_r[0].dir_x) * $signed(sb_r[0].dir_x));
      yy_r <= 32'($signed(sb_r[0].dir_y) * $signed(sb_r[0].dir_y));
      nsum_r <= xx_r + yy_r;
    end
  end

  eeml_isqrt #(.NW(NW)) u_isqrt (
    .clk      (clk),
    .en       (adv),
    .n_in     ({nsum_r, 16'd0}),
    .root_out (root)
  );

  // CORDIC operands
  logic [16:0] fx;
  logic [16:0] fy;
  logic        xneg;
  always_comb begin
    xneg = sb_r[PE-1].dir_x[15];
    fx = {sb_r[PE-1].dir_x[15], sb_r[PE-1].dir_x};
    fy = {sb_r[PE-1].dir_y[15], sb_r[PE-1].dir_y};
    if (xneg) begin
      fx = 17'd0 - fx;
      fy = 17'd0 - fy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r <= $signed({4'd0, root, 8'd0});
      ey_r <= $signed({{4{sb_r[PE-1].dir_z[15]}}, sb_r[PE-1].dir_z, 16'd0});
      ax_r <= $signed({{2{fx[16]}}, fx, 8'd0});
      ay_r <= $signed({{2{fy[16]}}, fy, 8'd0});
      aacc_r <= xneg ? 32'h8000_0000 : 32'd0;
    end
  end

  eeml_cordic #(.DW(EDW), .STEPS(STEPS)) u_cordic_elev (
    .clk     (clk),
    .en      (adv),
    .x_in    (ex_r),
    .y_in    (ey_r),
    .acc_in  (32'd0),
    .acc_out (acc_e)
  );

  eeml_cordic #(.DW(ADW), .STEPS(STEPS)) u_cordic_azim (
    .clk     (clk),
    .en      (adv),
    .x_in    (ax_r),
    .y_in    (ay_r),
    .acc_in  (aacc_r),
    .acc_out (acc_a)
  );

  // angles to texture fractions
  logic [31:0]        ae;
  logic [31:0]        az;
  logic signed [32:0] e_sum;
  logic signed [32:0] e_rnd;
  logic signed [34:0] v_s;
  logic [AB:0]        v_nxt;
  logic [31:0]        t_sum;
  logic [AB-1:0]      t2;
  always_comb begin
    ae = sb_r[PF-1].elev_zero ? 32'd0 : acc_e;
    az = sb_r[PF-1].azim_zero ? 32'd0 : acc_a;
    e_sum = $signed({ae[31], ae}) + (33'sd1 <<< (DROP - 1));
    e_rnd = e_sum >>> DROP;
    v_s = $signed(35'(HALF)) - $signed({e_rnd[32], e_rnd, 1'b0});
    if (v_s[34]) begin
      v_nxt = '0;
    end else if (v_s > $signed(35'(FULL))) begin
      v_nxt = (AB+1)'(FULL);
    end else begin
      v_nxt = v_s[AB:0];
    end
    t_sum = az + (32'd1 << (DROP - 1));
    t2 = t_sum[31:DROP] + AB'(HALF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r <= v_nxt;
      u_r <= {1'b0, AB'(0) - t2};
    end
  end

  // texel coordinates and index
  logic [AB+DIMW:0] pc;
  logic [AB+DIMW:0] pr;
  assign pc = (AB+DIMW+1)'(u_r) * (AB+DIMW+1)'(w_c - DIMW'(1));
  assign pr = (AB+DIMW+1)'(v_r) * (AB+DIMW+1)'(h_c - DIMW'(1));

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= pc[AB +: DIMW];
      row_r <= pr[AB +: DIMW];
      idx_r <= IW'(row_r) * IW'(w_c) + IW'(col_r);
    end
  end

  // reduce modulo store depth: reciprocal quotient, subtract, one correction
  assign qp = (2*IW)'(idx_r) * (2*IW)'(RECIP);
  assign qd = q_r * DEPTH_K;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= qp[2*IW-1:IW];
      idx_q_r <= idx_r;
      rm_r <= idx_q_r - qd;
      md_r <= (64'(rm_r) >= 64'(STORE_DEPTH)) ? (rm_r - DEPTH_K) : rm_r;
    end
  end

  // texel store
  logic [AW-1:0] wa;
  logic          wr_ok;
  assign wa = AW'(32'(sb_r[PI-1].load_address));
  assign wr_ok = 32'(sb_r[PI-1].load_address) < 32'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (adv && sb_r[PI-1].valid && (sb_r[PI-1].cmd == CMD_LOAD) && wr_ok) begin
      mem[wa] <= {sb_r[PI-1].load_red, sb_r[PI-1].load_green, sb_r[PI-1].load_blue};
    end
    if (adv) begin
      rd_r <= mem[AW'(md_r)];
    end
  end

  // gain and output register
  logic [31:0] pr_r;
  logic [31:0] pg_g;
  logic [31:0] pb_b;
  assign pr_r = 32'(rd_r[47:32]) * 32'(gain_r);
  assign pg_g = 32'(rd_r[31:16]) * 32'(gain_r);
  assign pb_b = 32'(rd_r[15:0]) * 32'(gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sb_r[PI].valid && (sb_r[PI].cmd == CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_r <= pr_r[31:8];
      out_green_r <= pg_g[31:8];
      out_blue_r <= pb_b[31:8];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red = out_red_r;
  assign out_green = out_green_r;
  assign out_blue = out_blue_r;

  a_load_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    adv && sb_r[PI].valid && (sb_r[PI].cmd == CMD_LOAD) |=> !out_valid_r)
    else $error("load produced a result beat");

  a_lookup_beat: assert property (@(posedge clk) disable iff (!rst_n)
    adv && sb_r[PI].valid && (sb_r[PI].cmd == CMD_LOOKUP) |=> out_valid_r)
    else $error("lookup lost its result beat");

  a_stall_read: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(rd_r))
    else $error("store read data moved during stall");

  a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
    sb_r[PF].valid && (sb_r[PF].cmd == CMD_LOOKUP) |-> (32'(v_r) <= 32'(FULL)))
    else $error("v fraction out of range");

endmodule

// ===== dv/tb.sv =====
// Testbench for equirect_env_map_lookup: texel loads and direction lookups,
// checked against a built-in fixed-point predictor of the lookup and texel store.
// Depends on eeml_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
  import eeml_pkg::*;

  typedef struct {
    bit [23:0] red;
    bit [23:0] green;
    bit [23:0] blue;
  } rgb_t;

  localparam bit [31:0] ARC_TURN [18] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215
  };
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_LOAD;
  logic signed [15:0] in_dir_x = '0;
  logic signed [15:0] in_dir_y = '0;
  logic signed [15:0] in_dir_z = '0;
  logic [15:0] in_load_address = '0;
  logic [15:0] in_load_red = '0;
  logic [15:0] in_load_green = '0;
  logic [15:0] in_load_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] out_red;
  logic [23:0] out_green;
  logic [23:0] out_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit [15:0] texel_r [65536];
  bit [15:0] texel_g [65536];
  bit [15:0] texel_b [65536];
  bit texel_loaded [65536];
  bit [8:0] width_reg = 9'd256;
  bit [8:0] height_reg = 9'd256;
  bit [15:0] gain_reg = 16'd256;

  rgb_t expected_rgb [$];
  rgb_t exp_rgb;
  int fail_count = 0;
  int lookup_count = 0;
  int load_count = 0;
  bit idle_on = 1'b1;

  equirect_env_map_lookup u_top (.*);

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) out_ready <= !idle_on || $urandom_range(0, 99) >= 20;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rgb.size() == 0) begin
        $error("unexpected result beat r=%0h g=%0h b=%0h", out_red, out_green, out_blue);
        fail_count++;
      end else begin
        exp_rgb = expected_rgb.pop_front();
        if (out_red !== exp_rgb.red) begin
          $error("out_red expected %0h actual %0h", exp_rgb.red, out_red);
          fail_count++;
        end
        if (out_green !== exp_rgb.green) begin
          $error("out_green expected %0h actual %0h", exp_rgb.green, out_green);
          fail_count++;
        end
        if (out_blue !== exp_rgb.blue) begin
          $error("out_blue expected %0h actual %0h", exp_rgb.blue, out_blue);
          fail_count++;
        end
      end
    end
  end

  function automatic longint int_sqrt(longint n);
    longint root;
    longint b;
    root = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    return root;
  endfunction

  function automatic bit [31:0] angle_turns(longint y, longint x);
    bit [31:0] acc;
    longint dx;
    longint dy;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + ARC_TURN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - ARC_TURN[i];
      end
    end
    return acc;
  endfunction

  function automatic longint clamp_dim(bit [8:0] d);
    if (d == 0) return 1;
    if (d > 256) return 256;
    return d;
  endfunction

  function automatic int texel_index(logic signed [15:0] sx, logic signed [15:0] sy,
                                     logic signed [15:0] sz);
    longint x, y, z, hl, e, v, t, u, w, h, col, row;
    bit [31:0] a;
    x = sx;
    y = sy;
    z = sz;
    hl = int_sqrt((x * x + y * y) * 65536);
    a = angle_turns(z * 256, hl);
    e = longint'($signed(a));
    e = (e + 32768) >>> 16;
    v = 32768 - 2 * e;
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    a = angle_turns(y, x) + 32'd32768;
    t = a[31:16];
    t = (t + 32768) & 65535;
    if (t == 0) t = 65536;
    u = 65536 - t;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    col = (u * (w - 1)) >>> 16;
    row = (v * (h - 1)) >>> 16;
    return int'((row * w + col) % 65536);
  endfunction

  function automatic bit [23:0] scale_channel(bit [15:0] c);
    bit [31:0] p;
    p = c * gain_reg;
    return p[31:8];
  endfunction

  task automatic send_beat(bit cmd, logic signed [15:0] dx, logic signed [15:0] dy,
                           logic signed [15:0] dz, bit [15:0] addr, bit [15:0] r,
                           bit [15:0] g, bit [15:0] b);
    int idx;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    in_load_address <= addr;
    in_load_red <= r;
    in_load_green <= g;
    in_load_blue <= b;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      texel_r[addr] = r;
      texel_g[addr] = g;
      texel_b[addr] = b;
      texel_loaded[addr] = 1'b1;
      load_count++;
    end else begin
      idx = texel_index(dx, dy, dz);
      expected_rgb.push_back('{scale_channel(texel_r[idx]), scale_channel(texel_g[idx]),
                               scale_channel(texel_b[idx])});
      lookup_count++;
    end
  endtask

  task automatic load_texel(bit [15:0] addr, bit [15:0] r, bit [15:0] g, bit [15:0] b);
    send_beat(CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), addr, r, g, b);
  endtask

  // load the target texel first if it was never written
  task automatic lookup_dir(logic signed [15:0] dx, logic signed [15:0] dy,
                            logic signed [15:0] dz);
    int idx;
    idx = texel_index(dx, dy, dz);
    if (!texel_loaded[idx]) begin
      load_texel(idx[15:0], 16'($urandom), 16'($urandom), 16'($urandom));
    end
    send_beat(CMD_LOOKUP, dx, dy, dz, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IMAGE_WIDTH) width_reg = data[8:0];
    else if (idx == CFG_IMAGE_HEIGHT) height_reg = data[8:0];
    else if (idx == CFG_POWER_GAIN) gain_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(bit [15:0] w, bit [15:0] h, bit [15:0] g);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_POWER_GAIN, g);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        load_texel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        lookup_dir(rand_comp(), rand_comp(), rand_comp());
      end
    end
  endtask

  task automatic test_directed();
    load_texel(16'd0, 16'h0000, 16'hffff, 16'h0000);
    load_texel(16'hffff, 16'hffff, 16'h0000, 16'hffff);
    lookup_dir(16'sd16384, 16'sd0, 16'sd0);
    lookup_dir(-16'sd16384, 16'sd0, 16'sd0);
    lookup_dir(16'sd0, 16'sd16384, 16'sd0);
    lookup_dir(16'sd0, -16'sd16384, 16'sd0);
    lookup_dir(16'sd0, 16'sd0, 16'sd16384);
    lookup_dir(16'sd0, 16'sd0, -16'sd16384);
    lookup_dir(16'sd0, 16'sd0, 16'sd0);
    lookup_dir(16'sh7fff, 16'sh7fff, 16'sh7fff);
    lookup_dir(16'sh8000, 16'sh8000, 16'sh8000);
    lookup_dir(16'sh8000, 16'sd0, 16'sh7fff);
    lookup_dir(16'sh8000, -16'sd1, 16'sd0);
    lookup_dir(16'sh8000, 16'sd1, 16'sd0);
    lookup_dir(16'sd1, 16'sd0, 16'sd0);
    lookup_dir(16'sd1, 16'sd1, 16'sh8000);
    lookup_dir(16'sd0, 16'sd0, -16'sd1);
  endtask

  task automatic test_config_sweep();
    configure(16'd1, 16'd1, 16'd0);
    random_items(50);
    configure(16'd0, 16'd0, 16'hffff);
    random_items(50);
    configure(16'd256, 16'd256, 16'd1);
    random_items(50);
    configure(16'h01ff, 16'd300, 16'd256);
    random_items(50);
    configure(16'd2, 16'd255, 16'($urandom));
    random_items(50);
    configure(16'($urandom_range(1, 256)), 16'($urandom_range(1, 256)), 16'($urandom));
    random_items(50);
  endtask

  task automatic test_random_stream();
    configure(16'd256, 16'd256, 16'd256);
    random_items(80);
    idle_on = 1'b0;
    random_items(80);
    idle_on = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    random_items(60);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_random_stream();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    $display("Covered %0d lookups and %0d texel loads over several image sizes and gains,",
             lookup_count, load_count);
    $display("with random gaps and stalls on both channels.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
